// ----- hw/rtl/atids_pkg.sv -----
// ============================================================================
// atids_pkg
// Shared types, codes and the control store for the ordered table block.
// ============================================================================
package atids_pkg;

    // Command codes carried in the slave-side tuser
    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_LSEARCH = 2'd2,
        CMD_BSEARCH = 2'd3
    } t_cmd;

    // Result status carried in the master-side tuser
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADIDX   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Control store addresses
    typedef enum logic [4:0] {
        U_FETCH = 5'd0,
        U_E_OK  = 5'd1,
        U_E_FULL = 5'd2,
        U_E_BAD = 5'd3,
        U_E_NF  = 5'd4,
        U_INS0  = 5'd5,
        U_INS1  = 5'd6,
        U_INS2  = 5'd7,
        U_INS3  = 5'd8,
        U_INS4  = 5'd9,
        U_DEL0  = 5'd10,
        U_DEL1  = 5'd11,
        U_DEL2  = 5'd12,
        U_DEL3  = 5'd13,
        U_LIN0  = 5'd14,
        U_LIN1  = 5'd15,
        U_LIN2  = 5'd16,
        U_LIN3  = 5'd17,
        U_LIN4  = 5'd18,
        U_BIN0  = 5'd19,
        U_BIN1  = 5'd20,
        U_BIN2  = 5'd21,
        U_BIN3  = 5'd22
    } t_step;

    // Sequencing kind
    typedef enum logic [1:0] {
        SQ_NEXT,    // fall through
        SQ_FETCH,   // wait for a beat, then dispatch on the command
        SQ_BR,      // jump to target when condition (xor inv) holds
        SQ_EMIT     // load the result register, then back to fetch
    } t_seq;

    // Branch conditions
    typedef enum logic [3:0] {
        C_TRUE,
        C_FULL,         // count reached depth
        C_POS_GT_CNT,
        C_POS_GE_CNT,
        C_I_EQ_POS,
        C_I1_EQ_POS,    // i-1 == pos
        C_I1_GE_CNT,    // i+1 >= count
        C_I2_GE_CNT,    // i+2 >= count
        C_CNT_ZERO,
        C_LIN_STOP,     // key match or last entry of a linear walk
        C_HIT,          // match seen in the previous cycle
        C_LO_GT_HI,
        C_MATCH
    } t_cond;

    // Index register operation
    typedef enum logic [2:0] {
        I_HOLD, I_CNT, I_POS, I_ZERO, I_INC, I_DEC
    } t_iop;

    // Read address select
    typedef enum logic [2:0] {
        RA_I, RA_IM1, RA_IM2, RA_IP1, RA_IP2, RA_MID
    } t_rsel;

    // Write select
    typedef enum logic [1:0] {
        W_NONE,     // no write
        W_SHIFT,    // mem[i] <= read data
        W_KEY       // mem[pos] <= key
    } t_wsel;

    // Count operation
    typedef enum logic [1:0] {
        CN_HOLD, CN_INC, CN_DEC
    } t_cop;

    // Found-index register operation
    typedef enum logic [1:0] {
        F_HOLD, F_ZERO, F_I, F_MID
    } t_fop;

    // Binary search bounds operation
    typedef enum logic [1:0] {
        B_HOLD, B_INIT, B_MID, B_UPD
    } t_bop;

    // One control word
    typedef struct packed {
        t_seq    seq;
        t_cond   cond;
        logic    inv;
        t_step   target;
        t_iop    iop;
        t_rsel   rsel;
        t_wsel   wsel;
        t_cop    cop;
        t_fop    fop;
        t_bop    bop;
        t_status st;
    } t_uword;

    localparam t_uword UW_NOP = '{
        seq: SQ_NEXT, cond: C_TRUE, inv: 1'b0, target: U_FETCH,
        iop: I_HOLD, rsel: RA_I, wsel: W_NONE, cop: CN_HOLD,
        fop: F_HOLD, bop: B_HOLD, st: ST_OK
    };

    // Entry point of each command routine
    function automatic t_step dispatch(input t_cmd cmd);
        t_step s;
        case (cmd)
            CMD_INSERT:  s = U_INS0;
            CMD_DELETE:  s = U_DEL0;
            CMD_LSEARCH: s = U_LIN0;
            CMD_BSEARCH: s = U_BIN0;
            default:     s = U_FETCH;
        endcase
        return s;
    endfunction

    // Control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = UW_NOP;
        case (s)
            U_FETCH: begin
                w.seq = SQ_FETCH; w.fop = F_ZERO;
            end
            U_E_OK: begin
                w.seq = SQ_EMIT; w.st = ST_OK;
            end
            U_E_FULL: begin
                w.seq = SQ_EMIT; w.st = ST_FULL;
            end
            U_E_BAD: begin
                w.seq = SQ_EMIT; w.st = ST_BADIDX;
            end
            U_E_NF: begin
                w.seq = SQ_EMIT; w.st = ST_NOTFOUND;
            end
            // insert: i walks down from count to pos, one move a cycle
            U_INS0: begin
                w.seq = SQ_BR; w.cond = C_FULL; w.target = U_E_FULL; w.iop = I_CNT;
            end
            U_INS1: begin
                w.seq = SQ_BR; w.cond = C_POS_GT_CNT; w.target = U_E_BAD;
            end
            U_INS2: begin
                w.seq = SQ_BR; w.cond = C_I_EQ_POS; w.target = U_INS4; w.rsel = RA_IM1;
            end
            U_INS3: begin
                w.seq = SQ_BR; w.cond = C_I1_EQ_POS; w.inv = 1'b1; w.target = U_INS3;
                w.wsel = W_SHIFT; w.rsel = RA_IM2; w.iop = I_DEC;
            end
            U_INS4: begin
                w.seq = SQ_BR; w.target = U_E_OK; w.wsel = W_KEY; w.cop = CN_INC;
            end
            // delete: i walks up from pos, one move a cycle
            U_DEL0: begin
                w.seq = SQ_BR; w.cond = C_POS_GE_CNT; w.target = U_E_BAD; w.iop = I_POS;
            end
            U_DEL1: begin
                w.seq = SQ_BR; w.cond = C_I1_GE_CNT; w.target = U_DEL3; w.rsel = RA_IP1;
            end
            U_DEL2: begin
                w.seq = SQ_BR; w.cond = C_I2_GE_CNT; w.inv = 1'b1; w.target = U_DEL2;
                w.wsel = W_SHIFT; w.rsel = RA_IP2; w.iop = I_INC;
            end
            U_DEL3: begin
                w.seq = SQ_BR; w.target = U_E_OK; w.cop = CN_DEC;
            end
            // linear search: one compare a cycle
            U_LIN0: begin
                w.seq = SQ_BR; w.cond = C_CNT_ZERO; w.target = U_E_NF; w.iop = I_ZERO;
            end
            U_LIN1: begin
                w.rsel = RA_I;
            end
            U_LIN2: begin
                w.seq = SQ_BR; w.cond = C_LIN_STOP; w.inv = 1'b1; w.target = U_LIN2;
                w.fop = F_I; w.iop = I_INC; w.rsel = RA_IP1;
            end
            U_LIN3: begin
                w.seq = SQ_BR; w.cond = C_HIT; w.target = U_E_OK;
            end
            U_LIN4: begin
                w.seq = SQ_BR; w.target = U_E_NF;
            end
            // binary search: each probe reads the midpoint, compares it, then loops back
            U_BIN0: begin
                w.bop = B_INIT;
            end
            U_BIN1: begin
                w.seq = SQ_BR; w.cond = C_LO_GT_HI; w.target = U_E_NF;
                w.bop = B_MID; w.rsel = RA_MID;
            end
            U_BIN2: begin
                w.seq = SQ_BR; w.cond = C_MATCH; w.target = U_E_OK;
                w.fop = F_MID; w.bop = B_UPD;
            end
            U_BIN3: begin
                w.seq = SQ_BR; w.target = U_BIN1;
            end
            default: begin
                w.seq = SQ_BR; w.target = U_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/array_table_insert_delete_search.sv -----
// Ordered table of signed 32-bit values with insert, delete, linear search and
// binary search. One beat in gives one beat out. Each command runs as a short
// microprogram over a single table memory with one read and one write port,
// so the cost per command follows the entries it touches: insert shifts the
// entries from the position up, delete shifts those above the position, linear
// search compares entries up to the match (all of them on a miss) and binary
// search reads one midpoint per probe. A rejected command (full table or bad
// index) moves no entries. Up to DEPTH entries are held; the count on the
// result is the number of entries after the command. Entries are not cleared
// at reset and need no clearing pass: only positions below the count are used.
// A new beat is taken while the previous result still waits at the output.
// ============================================================================
// array_table_insert_delete_search
// Microcoded ordered table: control store, step counter, shift/compare datapath.
// ============================================================================
module array_table_insert_delete_search #(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [7:0] position, [39:8] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] found_at, [16:8] count, rest zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import atids_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int IW   = AW + 1;                 // holds 0..DEPTH
    localparam int SW   = IW + 1;                 // signed search bounds
    localparam int CMPW = (IW > 8) ? IW : 8;      // position compares

    // Control state
    t_step             r_upc, n_upc;
    logic [IW-1:0]     r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;

    // Datapath registers
    logic [IW-1:0]     r_i, n_i;
    logic [7:0]        r_pos;
    logic [31:0]       r_key;
    logic [31:0]       r_rd;
    logic              r_hit;
    logic [7:0]        r_found, n_found;
    logic signed [SW-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    t_status           r_out_st;
    logic [7:0]        r_out_found;
    logic [8:0]        r_out_cnt;

    // Table memory
    logic [31:0]       r_mem [DEPTH];

    t_uword            uw;
    logic              s_acc, out_busy, emit, cond_raw, cond_ok, c_match;
    logic [IW-1:0]     im1, im2, ip1;
    logic [SW-1:0]     ip2, ip1w;
    logic signed [SW-1:0] sum_c, mid_c;
    logic [CMPW-1:0]   pos_x, cnt_x, i_x, im1_x;
    logic [AW-1:0]     ra, wa;
    logic [31:0]       wd;
    logic              we;

    assign uw = ucode(r_upc);

    // Handshake
    assign o_s_axis_tready = (uw.seq == SQ_FETCH);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_busy        = r_out_valid && !i_m_axis_tready;
    assign emit            = (uw.seq == SQ_EMIT) && !out_busy;

    // Index arithmetic
    assign im1   = r_i - 1'b1;
    assign im2   = r_i - 2'd2;
    assign ip1   = r_i + 1'b1;
    assign ip1w  = {1'b0, r_i} + 1'b1;
    assign ip2   = {1'b0, r_i} + 2'd2;
    assign pos_x = CMPW'(r_pos);
    assign cnt_x = CMPW'(r_cnt);
    assign i_x   = CMPW'(r_i);
    assign im1_x = CMPW'(im1);
    assign sum_c = r_lo + r_hi;
    assign mid_c = sum_c >>> 1;
    assign c_match = (r_rd == r_key);

    // Branch condition select
    always_comb begin
        case (uw.cond)
            C_TRUE:       cond_raw = 1'b1;
            C_FULL:       cond_raw = (r_cnt >= IW'(DEPTH));
            C_POS_GT_CNT: cond_raw = (pos_x > cnt_x);
            C_POS_GE_CNT: cond_raw = (pos_x >= cnt_x);
            C_I_EQ_POS:   cond_raw = (i_x == pos_x);
            C_I1_EQ_POS:  cond_raw = (im1_x == pos_x);
            C_I1_GE_CNT:  cond_raw = (ip1w >= {1'b0, r_cnt});
            C_I2_GE_CNT:  cond_raw = (ip2 >= {1'b0, r_cnt});
            C_CNT_ZERO:   cond_raw = (r_cnt == '0);
            C_LIN_STOP:   cond_raw = c_match || (ip1w == {1'b0, r_cnt});
            C_HIT:        cond_raw = r_hit;
            C_LO_GT_HI:   cond_raw = (r_lo > r_hi);
            C_MATCH:      cond_raw = c_match;
            default:      cond_raw = 1'b0;
        endcase
        cond_ok = cond_raw ^ uw.inv;
    end

    // Step counter
    always_comb begin
        case (uw.seq)
            SQ_NEXT:  n_upc = t_step'(r_upc + 1'b1);
            SQ_FETCH: n_upc = s_acc ? dispatch(t_cmd'(i_s_axis_tuser)) : r_upc;
            SQ_BR:    n_upc = cond_ok ? uw.target : t_step'(r_upc + 1'b1);
            SQ_EMIT:  n_upc = out_busy ? r_upc : U_FETCH;
            default:  n_upc = U_FETCH;
        endcase
    end

    // Index register
    always_comb begin
        case (uw.iop)
            I_HOLD:  n_i = r_i;
            I_CNT:   n_i = r_cnt;
            I_POS:   n_i = IW'(r_pos);
            I_ZERO:  n_i = '0;
            I_INC:   n_i = ip1;
            I_DEC:   n_i = im1;
            default: n_i = r_i;
        endcase
    end

    // Memory address and write select
    always_comb begin
        case (uw.rsel)
            RA_I:    ra = r_i[AW-1:0];
            RA_IM1:  ra = im1[AW-1:0];
            RA_IM2:  ra = im2[AW-1:0];
            RA_IP1:  ra = ip1[AW-1:0];
            RA_IP2:  ra = ip2[AW-1:0];
            RA_MID:  ra = mid_c[AW-1:0];
            default: ra = r_i[AW-1:0];
        endcase
        case (uw.wsel)
            W_SHIFT: begin
                we = 1'b1; wa = r_i[AW-1:0]; wd = r_rd;
            end
            W_KEY: begin
                we = 1'b1; wa = AW'(r_pos); wd = r_key;
            end
            default: begin
                we = 1'b0; wa = r_i[AW-1:0]; wd = r_rd;
            end
        endcase
    end

    // Count, found index, search bounds
    always_comb begin
        case (uw.cop)
            CN_INC:  n_cnt = r_cnt + 1'b1;
            CN_DEC:  n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
        case (uw.fop)
            F_ZERO:  n_found = '0;
            F_I:     n_found = 8'(r_i);
            F_MID:   n_found = 8'(r_mid);
            default: n_found = r_found;
        endcase
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_mid = r_mid;
        case (uw.bop)
            B_INIT: begin
                n_lo = '0;
                n_hi = $signed({1'b0, r_cnt}) - SW'(1);
            end
            B_MID:  n_mid = mid_c;
            B_UPD: begin
                if ($signed(r_rd) > $signed(r_key)) begin
                    n_hi = r_mid - SW'(1);
                end else begin
                    n_lo = r_mid + SW'(1);
                end
            end
            default: ;
        endcase
        n_out_valid = emit ? 1'b1 : out_busy;
    end

    // Control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= U_FETCH;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers and result payload
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_found <= n_found;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_hit   <= c_match;
        if (s_acc) begin
            r_pos <= i_s_axis_tdata[7:0];
            r_key <= i_s_axis_tdata[39:8];
        end
        if (emit) begin
            r_out_st    <= uw.st;
            r_out_found <= (uw.st == ST_OK) ? r_found : 8'd0;
            r_out_cnt   <= 9'(r_cnt);
        end
    end

    // Table memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_st;
    assign o_m_axis_tdata  = {7'd0, r_out_cnt, r_out_found};

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= IW'(DEPTH))
        else $error("entry count above depth");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (IW'(wa) <= r_cnt))
        else $error("table write beyond the stored entries");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |->
            ((r_cnt == $past(r_cnt) + 1'b1) || (r_cnt == $past(r_cnt) - 1'b1)))
        else $error("count moved by more than one");

    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_upc != U_FETCH))
        else $error("accepted beat not dispatched");

endmodule

// ----- verif/array_table_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// array_table_checker
// Watches both streams of the ordered table, predicts each result beat from
// its own copy of the table and compares field by field in arrival order.
// ============================================================================
module array_table_checker #(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,      // [7:0] position, [39:8] value
    input  logic [1:0]  i_s_tuser,      // [1:0] cmd
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,      // [7:0] found_at, [16:8] count, [23:17] zero
    input  logic [1:0]  i_m_tuser,      // [1:0] status
    output int          o_fail_cnt,
    output int          o_pending_cnt
);
    import atids_pkg::*;

    typedef struct packed {
        t_status    status;
        logic [7:0] found_at;
        logic [8:0] count;
    } t_table_result;

    // Mirror of the table contents and fill level
    logic signed [31:0] tbl_mirror [DEPTH];
    int                 fill_level = 0;
    t_table_result      results_due [$];
    t_table_result      head_res;
    int                 fail_cnt = 0;

    // Apply one command to the mirror and return the result it should give
    function automatic t_table_result apply_table_op(input t_cmd cmd, input logic [7:0] pos,
                                                     input logic signed [31:0] key);
        t_table_result r;
        int            i;
        int            lo;
        int            hi;
        int            mid;
        r.status   = ST_OK;
        r.found_at = '0;
        case (cmd)
            CMD_INSERT: begin
                if (fill_level >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (int'(pos) > fill_level) begin
                    r.status = ST_BADIDX;
                end else begin
                    for (i = fill_level; i > int'(pos); i--)
                        tbl_mirror[i] = tbl_mirror[i-1];
                    tbl_mirror[pos] = key;
                    fill_level++;
                end
            end
            CMD_DELETE: begin
                if (int'(pos) >= fill_level) begin
                    r.status = ST_BADIDX;
                end else begin
                    for (i = int'(pos); i + 1 < fill_level; i++)
                        tbl_mirror[i] = tbl_mirror[i+1];
                    fill_level--;
                end
            end
            CMD_LSEARCH: begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < fill_level; i++) begin
                    if (tbl_mirror[i] == key) begin
                        r.status   = ST_OK;
                        r.found_at = i[7:0];
                        break;
                    end
                end
            end
            default: begin
                // midpoint probes over 0..fill_level-1, ascending order assumed
                r.status = ST_NOTFOUND;
                lo = 0;
                hi = fill_level - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (tbl_mirror[mid] == key) begin
                        r.status   = ST_OK;
                        r.found_at = mid[7:0];
                        break;
                    end else if (tbl_mirror[mid] > key) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
        endcase
        r.count = fill_level[8:0];
        return r;
    endfunction

    // Result beats are checked before the same edge's command beat is queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_level = 0;
            results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result beat with nothing due: status %0d found_at %0d count %0d",
                             $time, i_m_tuser, i_m_tdata[7:0], i_m_tdata[16:8]);
                end else begin
                    head_res = results_due.pop_front();
                    if (i_m_tuser !== head_res.status) begin
                        fail_cnt++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, head_res.status, i_m_tuser);
                    end
                    if (i_m_tdata[7:0] !== head_res.found_at) begin
                        fail_cnt++;
                        $display("%0t: found_at mismatch, expected %0d, got %0d",
                                 $time, head_res.found_at, i_m_tdata[7:0]);
                    end
                    if (i_m_tdata[16:8] !== head_res.count) begin
                        fail_cnt++;
                        $display("%0t: count mismatch, expected %0d, got %0d",
                                 $time, head_res.count, i_m_tdata[16:8]);
                    end
                    if (i_m_tdata[23:17] !== 7'd0) begin
                        fail_cnt++;
                        $display("%0t: tdata pad mismatch, expected 0, got %h",
                                 $time, i_m_tdata[23:17]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(apply_table_op(t_cmd'(i_s_tuser), i_s_tdata[7:0],
                                                     i_s_tdata[39:8]));
        end
        o_fail_cnt    <= fail_cnt;
        o_pending_cnt <= results_due.size();
    end

endmodule

// ----- verif/tb_array_table_insert_delete_search.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_array_table_insert_delete_search
// Drives commands into the ordered table under changing backpressure and
// leaves all result checking to the checker beside the block.
// ============================================================================
module tb_array_table_insert_delete_search;
    import atids_pkg::*;

    localparam int     DEPTH        = 256;
    localparam longint RUN_LIMIT_NS = 20_000_000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;         // [7:0] position, [39:8] value
    logic [1:0]  s_tuser  = CMD_INSERT; // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;               // [7:0] found_at, [16:8] count, rest zero
    logic [1:0]  m_tuser;               // [1:0] status
    int          fail_cnt;
    int          pending_cnt;

    int unsigned tx_idle_pct = 35;
    int unsigned rx_idle_pct = 73;

    // Contents as the stimulus expects them, used to aim positions and keys
    int table_image [$];
    int n_by_cmd [4] = '{0, 0, 0, 0};
    int n_full_refused = 0;
    int peak_fill = 0;

    array_table_insert_delete_search #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    array_table_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_cnt    (fail_cnt),
        .o_pending_cnt (pending_cnt)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side backpressure
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Hard stop
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout after %0d ns with %0d results outstanding", RUN_LIMIT_NS, pending_cnt);
        $display("TEST FAILED");
        $finish;
    end

    // Send one command beat, with random idle cycles ahead of it
    task automatic issue(input t_cmd cmd, input logic [7:0] pos, input logic [31:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, pos};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_by_cmd[cmd]++;
        case (cmd)
            CMD_INSERT: begin
                if (table_image.size() >= DEPTH)
                    n_full_refused++;
                else if (int'(pos) <= table_image.size())
                    table_image.insert(int'(pos), int'(val));
            end
            CMD_DELETE: begin
                if (int'(pos) < table_image.size())
                    table_image.delete(int'(pos));
            end
            default: ;
        endcase
        if (table_image.size() > peak_fill)
            peak_fill = table_image.size();
    endtask

    // Slot that keeps the entries ascending
    function automatic int sorted_slot(input int val);
        int k;
        k = 0;
        while (k < table_image.size() && table_image[k] <= val) k++;
        return k;
    endfunction

    // Small values make duplicates likely, the rest spans all 32 bits
    function automatic int rand_value();
        if ($urandom_range(0, 99) < 40)
            return int'($urandom_range(0, 400)) - 200;
        return $urandom;
    endfunction

    // Mostly stored keys, some near misses, some anything
    function automatic int pick_key();
        int roll;
        int sz;
        roll = $urandom_range(0, 99);
        sz   = table_image.size();
        if (sz != 0 && roll < 60)
            return table_image[$urandom_range(0, sz - 1)];
        if (sz != 0 && roll < 80)
            return table_image[$urandom_range(0, sz - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        return $urandom;
    endfunction

    // One random command; a small share is raw noise over every field
    task automatic random_item(input int w_ins, input int w_del, input int w_lin);
        int roll;
        int val;
        int sz;
        sz   = table_image.size();
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            issue(t_cmd'($urandom_range(0, 3)), 8'($urandom), $urandom);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < w_ins) begin
                val = rand_value();
                issue(CMD_INSERT, 8'(sorted_slot(val)), val);
            end else if (roll < w_ins + w_del) begin
                if (sz == 0)
                    issue(CMD_DELETE, 8'($urandom), $urandom);
                else
                    issue(CMD_DELETE, 8'($urandom_range(0, sz - 1)), $urandom);
            end else if (roll < w_ins + w_del + w_lin) begin
                issue(CMD_LSEARCH, 8'($urandom), pick_key());
            end else begin
                issue(CMD_BSEARCH, 8'($urandom), pick_key());
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: searches miss, delete and out-of-range insert refused
        issue(CMD_LSEARCH, 8'd0, 32'd0);
        issue(CMD_BSEARCH, 8'd0, 32'd0);
        issue(CMD_DELETE, 8'd0, 32'd0);
        issue(CMD_INSERT, 8'd1, 32'd7);
        issue(CMD_INSERT, 8'hFF, 32'hA5A5_A5A5);
        // build min, -1, 0, max
        issue(CMD_INSERT, 8'd0, 32'd0);
        issue(CMD_INSERT, 8'd1, 32'h7FFF_FFFF);
        issue(CMD_INSERT, 8'd0, 32'h8000_0000);
        issue(CMD_INSERT, 8'd1, 32'hFFFF_FFFF);
        issue(CMD_BSEARCH, 8'hFF, 32'h7FFF_FFFF);
        issue(CMD_BSEARCH, 8'd0, 32'h8000_0000);
        issue(CMD_BSEARCH, 8'd0, 32'hFFFF_FFFF);
        issue(CMD_BSEARCH, 8'd0, 32'd0);
        issue(CMD_BSEARCH, 8'd0, 32'd1);
        issue(CMD_LSEARCH, 8'hFF, 32'd0);
        issue(CMD_LSEARCH, 8'd0, 32'd5);
        // duplicate key: linear search reports the lower slot
        issue(CMD_INSERT, 8'd2, 32'hFFFF_FFFF);
        issue(CMD_LSEARCH, 8'd0, 32'hFFFF_FFFF);
        // append out of order, then search the unsorted table
        issue(CMD_INSERT, 8'd5, 32'd5);
        issue(CMD_BSEARCH, 8'd0, 32'd5);
        issue(CMD_LSEARCH, 8'd0, 32'd5);
        // delete past the end, last, first, middle
        issue(CMD_DELETE, 8'd6, 32'd0);
        issue(CMD_DELETE, 8'd5, 32'd0);
        issue(CMD_DELETE, 8'd0, 32'd0);
        issue(CMD_DELETE, 8'd1, 32'd0);

        // mixed traffic, slow sender, slower receiver
        repeat (60) random_item(45, 15, 20);

        // fill to the top with the idling swapped
        tx_idle_pct = 73;
        rx_idle_pct = 35;
        while (table_image.size() < DEPTH) random_item(85, 3, 6);
        issue(CMD_INSERT, 8'hFF, 32'd1);
        issue(CMD_DELETE, 8'hFF, 32'd0);
        issue(CMD_INSERT, 8'hFF, 32'h7FFF_FFFF);
        issue(CMD_INSERT, 8'd0, 32'h8000_0000);
        repeat (40) random_item(40, 10, 25);

        // drain at full rate
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (table_image.size() > 8) random_item(5, 85, 5);
        repeat (20) random_item(30, 30, 20);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Covered %0d beats: %0d insert, %0d delete, %0d linear, %0d binary search",
                 n_by_cmd[0] + n_by_cmd[1] + n_by_cmd[2] + n_by_cmd[3],
                 n_by_cmd[CMD_INSERT], n_by_cmd[CMD_DELETE],
                 n_by_cmd[CMD_LSEARCH], n_by_cmd[CMD_BSEARCH]);
        $display("Table peaked at %0d of %0d entries; %0d inserts hit a full table",
                 peak_fill, DEPTH, n_full_refused);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/atids_pkg.sv
hw/rtl/array_table_insert_delete_search.sv
verif/array_table_checker.sv
verif/tb_array_table_insert_delete_search.sv
